// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CRCBE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define CRCBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define CRCBE_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/crcbe_pkg.sv =====
package crcbe_pkg;

  localparam int CRC_W = 128;
  localparam int HALF_W = 64;
  localparam int BYTE_W = 8;

  localparam logic [CRC_W-1:0] POLY_RESET = {64'h0000_0000_0000_0001,
                                             64'hFFFF_FFFF_FFFF_FFFF};
  localparam logic [CRC_W-1:0] INIT_RESET = '0;
  localparam logic [CRC_W-1:0] XOROUT_RESET = '0;

  typedef enum logic [2:0] {
    REG_POLY_UPPER     = 3'd0,
    REG_POLY_LOWER     = 3'd1,
    REG_INIT_UPPER     = 3'd2,
    REG_INIT_LOWER     = 3'd3,
    REG_XOROUT_UPPER   = 3'd4,
    REG_XOROUT_LOWER   = 3'd5,
    REG_REFLECT_IN_EN  = 3'd6,
    REG_REFLECT_OUT_EN = 3'd7
  } crcbe_reg_t;

  typedef struct packed {
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] init;
    logic [CRC_W-1:0] xorout;
    logic             in_flip;
    logic             out_flip;
  } crcbe_cfg_t;

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] rev128(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== src/crc128_byte_engine_core.sv =====
// Channel  | Handshake            | Word
// ---------+----------------------+--------------------------------
// in       | in_valid / in_stall  | data_byte[7:0], last_byte
// out      | out_valid / out_stall| crc_upper[63:0], crc_lower[63:0]
// config   | cfg_we (no wait)     | cfg_index[2:0], cfg_data[63:0]
//
// One byte is taken per cycle while in_stall is low; the eight-bit CRC update is
// one combinational pass from the CRC register back into itself, so a new byte
// can follow every cycle. A finished CRC enters the output buffer as its last
// byte is taken; this two-word buffer lets bytes keep flowing while a result is
// stalled, and in_stall is raised only when both buffer words are held.
// Reset loads the default polynomial, a zero start value and an empty buffer.
module crc128_byte_engine_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [63:0]  crc_upper,
  output logic [63:0]  crc_lower
);
  import crcbe_pkg::*;

  crcbe_cfg_t       cfg;
  logic [CRC_W-1:0] crc;
  logic [CRC_W-1:0] crc_next;
  logic [CRC_W-1:0] result;
  logic [CRC_W-1:0] out_data;
  logic             accept;
  logic             full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  crcbe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crcbe_step u_step (
    .cfg       (cfg),
    .crc       (crc),
    .data_byte (data_byte),
    .crc_next  (crc_next),
    .result    (result)
  );

  // The register restarts from the start value after each message.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= INIT_RESET;
    end else if (accept) begin
      crc <= last_byte ? cfg.init : crc_next;
    end
  end

  crcbe_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && last_byte),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign crc_upper = out_data[CRC_W-1:HALF_W];
  assign crc_lower = out_data[HALF_W-1:0];

endmodule

// ===== src/crcbe_cfg.sv =====
module crcbe_cfg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  output crcbe_pkg::crcbe_cfg_t  cfg
);
  import crcbe_pkg::*;

  crcbe_reg_t idx;

  assign idx = crcbe_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poly     <= POLY_RESET;
      cfg.init     <= INIT_RESET;
      cfg.xorout   <= XOROUT_RESET;
      cfg.in_flip  <= 1'b0;
      cfg.out_flip <= 1'b0;
    end else if (cfg_we) begin
      unique case (idx)
        REG_POLY_UPPER:     cfg.poly[CRC_W-1:HALF_W]   <= cfg_data;
        REG_POLY_LOWER:     cfg.poly[HALF_W-1:0]       <= cfg_data;
        REG_INIT_UPPER:     cfg.init[CRC_W-1:HALF_W]   <= cfg_data;
        REG_INIT_LOWER:     cfg.init[HALF_W-1:0]       <= cfg_data;
        REG_XOROUT_UPPER:   cfg.xorout[CRC_W-1:HALF_W] <= cfg_data;
        REG_XOROUT_LOWER:   cfg.xorout[HALF_W-1:0]     <= cfg_data;
        REG_REFLECT_IN_EN:  cfg.in_flip                <= cfg_data[0];
        REG_REFLECT_OUT_EN: cfg.out_flip               <= cfg_data[0];
        default:            cfg.poly                   <= cfg.poly;
      endcase
    end
  end

endmodule

// ===== src/crcbe_step.sv =====
module crcbe_step (
  input  crcbe_pkg::crcbe_cfg_t  cfg,
  input  logic [127:0]           crc,
  input  logic [7:0]             data_byte,
  output logic [127:0]           crc_next,
  output logic [127:0]           result
);
  import crcbe_pkg::*;

  logic [BYTE_W-1:0] byte_in;
  logic [CRC_W-1:0]  v;

  assign byte_in = cfg.in_flip ? rev8(data_byte) : data_byte;

  // Eight MSB-first shifts; the x^128 term is implied by the bit shifted out.
  always_comb begin
    v = crc ^ {byte_in, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      v = {v[CRC_W-2:0], 1'b0} ^ (v[CRC_W-1] ? cfg.poly : '0);
    end
  end

  assign crc_next = v;

  // Output reflection comes before the final XOR.
  assign result = (cfg.out_flip ? rev128(v) : v) ^ cfg.xorout;

endmodule

// ===== src/crcbe_outbuf.sv =====
module crcbe_outbuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [127:0]  push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [127:0]  out_data
);
  import crcbe_pkg::*;

  logic [1:0]       count;
  logic [1:0]       count_next;
  logic [CRC_W-1:0] slot0;
  logic [CRC_W-1:0] slot1;
  logic             pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot0;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Slot 0 is the head word shown on the output; slot 1 catches a word
  // that arrives while the head is stalled.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
      end
      if (push) begin
        slot1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

// ===== src/crcbe_checker.sv =====
`include "assert_macros.svh"

module crcbe_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_stall,
  input  logic         last_byte,
  input  logic         out_valid,
  input  logic         out_stall,
  input  logic [63:0]  crc_upper,
  input  logic [63:0]  crc_lower
);

  // A stalled result word stays put.
  `CRCBE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(crc_upper) && $stable(crc_lower))

  // Reset leaves no result pending.
  `CRCBE_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)

  // A result only appears after a last byte was taken.
  `CRCBE_ASSERT_NOW(a_result_source, clk, rst, $rose(out_valid), $past(in_valid && !in_stall && last_byte))

  // With nothing waiting on the output, input bytes are never held off.
  `CRCBE_ASSERT_NOW(a_no_stall_empty, clk, rst, !out_valid, !in_stall)

endmodule

bind crc128_byte_engine_core crcbe_checker u_crcbe_checker (.*);
